@@ rtl/core/jsp_pkg.sv @@
// Shared widths, register codes and payload types of the stencil point update.
`default_nettype none
package jsp_pkg;

  localparam int VALUE_W     = 48;
  localparam int MAX_POINTS  = 1024;
  localparam int INDEX_W     = 10;
  localparam int CFG_W       = 32;
  localparam int EPS_W       = 40;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 40;
  localparam int FRAC_STEP   = 30;

  // coordinate path
  localparam int PROD_W = INDEX_W + CFG_W;
  localparam int SQ_W   = 2 * PROD_W;
  localparam int P_W    = SQ_W + 2;
  localparam int C2_W   = (P_W - 64) + CFG_W;

  // neighbour path
  localparam int SUM_W = VALUE_W + 1;
  localparam int PPH_W = (SUM_W - 32) + 33;
  localparam int T_W   = PPH_W + 32;

  // numerator, denominator and quotient
  localparam int NW    = ((VALUE_W + 56 > 120) ? VALUE_W + 56 : 120) + 1;
  localparam int DEN_W = CFG_W + 4;
  localparam int DD_W  = DEN_W + 20;
  localparam int QW    = VALUE_W + 1;
  localparam int CW    = ((NW > DD_W + QW) ? NW : DD_W + QW) + 1;
  localparam int CMP_W = (SUM_W > EPS_W) ? SUM_W : EPS_W;

  localparam logic [CFG_W-1:0] INV_SQ_RST = 32'd14700000;
  localparam logic [CFG_W-1:0] STEP_RST   = 32'd4483264;
  localparam logic [CFG_W-1:0] COEF_RST   = 32'd25600000;
  localparam logic [EPS_W-1:0] EPS_RST    = 40'd10995;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_SQ_X = 4'd0,
    REG_INV_SQ_Y = 4'd1,
    REG_INV_SQ_Z = 4'd2,
    REG_STEP_X   = 4'd3,
    REG_STEP_Y   = 4'd4,
    REG_STEP_Z   = 4'd5,
    REG_COEF_A   = 4'd6,
    REG_EPSILON  = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [VALUE_W-1:0] center_old;
    logic signed [VALUE_W-1:0] west;
    logic signed [VALUE_W-1:0] east;
    logic signed [VALUE_W-1:0] south;
    logic signed [VALUE_W-1:0] north;
    logic signed [VALUE_W-1:0] below;
    logic signed [VALUE_W-1:0] above;
    logic [INDEX_W-1:0]        index_x;
    logic [INDEX_W-1:0]        index_y;
    logic [INDEX_W-1:0]        index_z;
  } jsp_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] new_value;
    logic                      exceeded;
    logic                      overflow;
  } jsp_out_t;

  // travels alongside the quotient through the divider
  typedef struct packed {
    logic                      neg;
    logic                      big;
    logic                      dz;
    logic                      nz;
    logic signed [VALUE_W-1:0] center;
  } div_side_t;

endpackage
`default_nettype wire

@@ rtl/core/jsp_div.sv @@
// Restoring divider, one quotient bit per pipeline stage.
`default_nettype none
module jsp_div import jsp_pkg::*; (
  input  logic            clk_i,
  input  logic [QW-1:0]   en_i,
  input  logic [CW-1:0]   n_i,
  input  logic [DD_W-1:0] d_i,
  input  div_side_t       side_i,
  output logic [QW-1:0]   q_o,
  output div_side_t       side_o
);

  logic [CW-1:0]   r_q  [QW];
  logic [DD_W-1:0] d_q  [QW];
  logic [QW-1:0]   qb_q [QW];
  div_side_t       s_q  [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [CW-1:0]   r_in;
    logic [CW-1:0]   sub;
    logic [DD_W-1:0] d_in;
    logic [QW-1:0]   q_in;
    div_side_t       s_in;
    logic            take;

    if (j == 0) begin : g_first
      assign r_in = n_i;
      assign d_in = d_i;
      assign q_in = '0;
      assign s_in = side_i;
    end else begin : g_next
      assign r_in = r_q[j-1];
      assign d_in = d_q[j-1];
      assign q_in = qb_q[j-1];
      assign s_in = s_q[j-1];
    end

    assign sub  = CW'(d_in) << (QW - 1 - j);
    assign take = (r_in >= sub);

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        r_q[j]  <= take ? (r_in - sub) : r_in;
        d_q[j]  <= d_in;
        qb_q[j] <= {q_in[QW-2:0], take};
        s_q[j]  <= s_in;
      end
    end
  end

  assign q_o    = qb_q[QW-1];
  assign side_o = s_q[QW-1];

endmodule
`default_nettype wire

@@ rtl/core/jacobi_stencil_point_update.sv @@
// Top level: pipelined Jacobi update of one 3D Helmholtz grid point.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------
//  in      | input     | in_valid_i/in_stall_o   | in_data_i  (jsp_in_t)
//  out     | output    | out_valid_o/out_stall_i | out_data_o (jsp_out_t)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One point per cycle unless a stall holds a full pipeline; its core is
// the restoring divider that resolves one quotient bit per stage.
// Reset clears the stage valid bits and loads the register defaults.
// A stall holds only the full stages at the output end; bubbles ahead of
// them still close up, so input is taken while any stage is empty.
`default_nettype none
module jacobi_stencil_point_update import jsp_pkg::*; #(
  parameter int MAX_POINTS_PER_AXIS = MAX_POINTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  jsp_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output jsp_out_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int ST_DIV = 9;
  localparam int ST_F1  = ST_DIV + QW;
  localparam int NS     = ST_F1 + 2;
  localparam logic [PROD_W-1:0] ONE = PROD_W'(1) << FRAC_STEP;

  function automatic logic [INDEX_W-1:0] clamp_idx(input logic [INDEX_W-1:0] idx);
    if (32'(idx) > MAX_POINTS_PER_AXIS - 1) return INDEX_W'(MAX_POINTS_PER_AXIS - 1);
    return idx;
  endfunction

  // configuration registers
  logic [CFG_W-1:0] inv_q [3];
  logic [CFG_W-1:0] step_q [3];
  logic [CFG_W-1:0] coef_q;
  logic [EPS_W-1:0] eps_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q[0]  <= INV_SQ_RST;
      inv_q[1]  <= INV_SQ_RST;
      inv_q[2]  <= INV_SQ_RST;
      step_q[0] <= STEP_RST;
      step_q[1] <= STEP_RST;
      step_q[2] <= STEP_RST;
      coef_q    <= COEF_RST;
      eps_q     <= EPS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_INV_SQ_X: inv_q[0]  <= cfg_data_i[CFG_W-1:0];
        REG_INV_SQ_Y: inv_q[1]  <= cfg_data_i[CFG_W-1:0];
        REG_INV_SQ_Z: inv_q[2]  <= cfg_data_i[CFG_W-1:0];
        REG_STEP_X:   step_q[0] <= cfg_data_i[CFG_W-1:0];
        REG_STEP_Y:   step_q[1] <= cfg_data_i[CFG_W-1:0];
        REG_STEP_Z:   step_q[2] <= cfg_data_i[CFG_W-1:0];
        REG_COEF_A:   coef_q    <= cfg_data_i[CFG_W-1:0];
        REG_EPSILON:  eps_q     <= cfg_data_i[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // the user must keep the denominator static while points are in flight; the block does not enforce it
  logic [DEN_W-1:0] den;
  logic [DD_W-1:0]  dd;
  assign den = ((DEN_W'(inv_q[0]) + DEN_W'(inv_q[1]) + DEN_W'(inv_q[2])) << 1)
               + DEN_W'(coef_q);
  assign dd  = {den, 20'b0};

  // stage valids and enables
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = !(&v_q[NS-1:k]) || !out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (en & {v_q[NS-2:0], in_valid_i}) | (~en & v_q);
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[NS-1];

  logic signed [VALUE_W-1:0] center_q [ST_DIV-1];

  always_ff @(posedge clk_i) begin
    if (en[0]) center_q[0] <= in_data_i.center_old;
    for (int k = 1; k < ST_DIV - 1; k++) begin
      if (en[k]) center_q[k] <= center_q[k-1];
    end
  end

  // stage 0: neighbour pair sums, index times step
  logic signed [SUM_W-1:0] s_d [3], s_q [3];
  logic [PROD_W-1:0]       pr_d [3], pr_q [3];

  always_comb begin
    s_d[0]  = SUM_W'(in_data_i.below) + SUM_W'(in_data_i.above);
    s_d[1]  = SUM_W'(in_data_i.south) + SUM_W'(in_data_i.north);
    s_d[2]  = SUM_W'(in_data_i.west) + SUM_W'(in_data_i.east);
    pr_d[0] = PROD_W'(clamp_idx(in_data_i.index_x)) * PROD_W'(step_q[0]);
    pr_d[1] = PROD_W'(clamp_idx(in_data_i.index_y)) * PROD_W'(step_q[1]);
    pr_d[2] = PROD_W'(clamp_idx(in_data_i.index_z)) * PROD_W'(step_q[2]);
  end

  // stage 1: neighbour partial products, coordinate magnitude
  logic [63:0]             pl_d [3], pl_q [3];
  logic signed [PPH_W-1:0] ph_d [3], ph_q [3];
  logic [PROD_W-1:0]       mg_d [3], mg_q [3];

  // stage 2: neighbour terms, square partial products
  logic signed [T_W-1:0] t_d [3], t_q [3];
  logic [63:0]           ll_d [3], ll_q [3];
  logic [PROD_W-1:0]     lh_d [3], lh_q [3];
  logic [19:0]           hh_d [3], hh_q [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      pl_d[a] = 64'(s_q[a][31:0]) * 64'(inv_q[a]);
      ph_d[a] = $signed(s_q[a][SUM_W-1:32]) * $signed({1'b0, inv_q[a]});
      mg_d[a] = (pr_q[a] >= ONE) ? (pr_q[a] - ONE) : (ONE - pr_q[a]);
      t_d[a]  = $signed({ph_q[a], 32'b0}) + $signed({{(T_W-64){1'b0}}, pl_q[a]});
      ll_d[a] = 64'(mg_q[a][31:0]) * 64'(mg_q[a][31:0]);
      lh_d[a] = PROD_W'(mg_q[a][31:0]) * PROD_W'(mg_q[a][PROD_W-1:32]);
      hh_d[a] = 20'(mg_q[a][PROD_W-1:32]) * 20'(mg_q[a][PROD_W-1:32]);
    end
  end

  // stage 3: neighbour numerator at Q.68, squares assembled
  logic signed [NW-1:0] nn_d, nn_q [3:5];
  logic [SQ_W-1:0]      sq_d [3], sq_q [3];

  always_comb begin
    nn_d = (NW'(t_q[0]) + NW'(t_q[1]) + NW'(t_q[2])) <<< 20;
    for (int a = 0; a < 3; a++) begin
      sq_d[a] = (SQ_W'(hh_q[a]) << 64) + (SQ_W'(lh_q[a]) << 33) + SQ_W'(ll_q[a]);
    end
  end

  // stage 4: sum of squares; stage 5: times coef_a in slices
  logic [P_W-1:0]  p_d, p_q;
  logic [63:0]     c0_d, c0_q, c1_d, c1_q;
  logic [C2_W-1:0] c2_d, c2_q;

  // stage 6: full numerator; stage 7: magnitude plus half divisor
  logic signed [NW-1:0] num_d, num_q;
  logic [NW-1:0]        absn;
  logic [CW-1:0]        n_d, n_q7, n_q8;
  logic                 neg_q7, dz_q7;
  div_side_t            side_d, side_q8;

  always_comb begin
    p_d   = P_W'(sq_q[0]) + P_W'(sq_q[1]) + P_W'(sq_q[2]);
    c0_d  = 64'(p_q[31:0]) * 64'(coef_q);
    c1_d  = 64'(p_q[63:32]) * 64'(coef_q);
    c2_d  = C2_W'(p_q[P_W-1:64]) * C2_W'(coef_q);
    num_d = nn_q[5] + $signed(NW'(c0_q)) + $signed(NW'(c1_q) << 32)
            + $signed(NW'(c2_q) << 64) - $signed(NW'(6) << 68);
    absn  = num_q[NW-1] ? NW'(-num_q) : NW'(num_q);
    n_d   = CW'(absn) + CW'(dd >> 1);
    side_d.neg    = neg_q7;
    side_d.dz     = dz_q7;
    side_d.big    = (n_q7 >= (CW'(dd) << QW));
    side_d.nz     = (n_q7 != '0);
    side_d.center = center_q[7];
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s_q  <= s_d;
      pr_q <= pr_d;
    end
    if (en[1]) begin
      pl_q <= pl_d;
      ph_q <= ph_d;
      mg_q <= mg_d;
    end
    if (en[2]) begin
      t_q  <= t_d;
      ll_q <= ll_d;
      lh_q <= lh_d;
      hh_q <= hh_d;
    end
    if (en[3]) begin
      nn_q[3] <= nn_d;
      sq_q    <= sq_d;
    end
    if (en[4]) begin
      nn_q[4] <= nn_q[3];
      p_q     <= p_d;
    end
    if (en[5]) begin
      nn_q[5] <= nn_q[4];
      c0_q    <= c0_d;
      c1_q    <= c1_d;
      c2_q    <= c2_d;
    end
    if (en[6]) begin
      num_q   <= num_d;
    end
    if (en[7]) begin
      n_q7   <= n_d;
      neg_q7 <= num_q[NW-1];
      dz_q7  <= (den == '0);
    end
    if (en[8]) begin
      n_q8    <= n_q7;
      side_q8 <= side_d;
    end
  end

  // quotient bits, one per stage
  logic [QW-1:0] q_div;
  div_side_t     side_div;

  jsp_div u_div (
    .clk_i  (clk_i),
    .en_i   (en[ST_DIV +: QW]),
    .n_i    (n_q8),
    .d_i    (dd),
    .side_i (side_q8),
    .q_o    (q_div),
    .side_o (side_div)
  );

  // saturate and restore the sign
  logic [QW-1:0]             lim, qs;
  logic                      ov_d, ov_q;
  logic signed [VALUE_W-1:0] val_d, val_q, old_q;
  logic signed [SUM_W-1:0]   diff;
  logic [SUM_W-1:0]          adiff;
  jsp_out_t                  out_d, out_q;

  always_comb begin
    lim = side_div.neg ? (QW'(1) << (VALUE_W - 1)) : ((QW'(1) << (VALUE_W - 1)) - 1'b1);
    if (side_div.dz) begin
      qs   = side_div.nz ? lim : '0;
      ov_d = side_div.nz;
    end else if (side_div.big || (q_div > lim)) begin
      qs   = lim;
      ov_d = 1'b1;
    end else begin
      qs   = q_div;
      ov_d = 1'b0;
    end
    val_d = side_div.neg ? VALUE_W'(-qs) : VALUE_W'(qs);

    diff  = SUM_W'(val_q) - SUM_W'(old_q);
    adiff = diff[SUM_W-1] ? SUM_W'(-diff) : SUM_W'(diff);
    out_d.new_value = val_q;
    out_d.exceeded  = (CMP_W'(adiff) > CMP_W'(eps_q));
    out_d.overflow  = ov_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_F1]) begin
      val_q <= val_d;
      old_q <= side_div.center;
      ov_q  <= ov_d;
    end
    if (en[NS-1]) out_q <= out_d;
  end

  assign out_data_o = out_q;

`ifndef SYNTH
  a_ovf_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |->
      (out_data_o.new_value == {1'b0, {(VALUE_W-1){1'b1}}}) ||
      (out_data_o.new_value == {1'b1, {(VALUE_W-1){1'b0}}}))
    else $error("overflow flagged on an unsaturated value");
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q) && out_stall_i)
    else $error("input stalled while the pipeline has a free stage");
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> v_q[0])
    else $error("accepted transaction did not enter the first stage");
`endif

endmodule
`default_nettype wire

@@ bench/jsp_checker.sv @@
// Checker: predicts each point update from the input transactions and compares the results.
`timescale 1ns / 1ps
module jsp_checker import jsp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  jsp_in_t               in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  jsp_out_t              out_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    errors_o,
  output int                    pending_o,
  output int                    checked_o
);

  typedef logic signed [255:0] wide_t;

  logic [CFG_W-1:0] inv_x, inv_y, inv_z, stp_x, stp_y, stp_z, coef;
  logic [EPS_W-1:0] eps;
  jsp_out_t         expected_points[$];
  int               errors, checked;

  assign errors_o  = errors;
  assign pending_o = expected_points.size();
  assign checked_o = checked;

  function automatic wide_t widen(logic [VALUE_W-1:0] v);
    return {{(256-VALUE_W){v[VALUE_W-1]}}, v};
  endfunction

  function automatic wide_t unsigned_wide(logic [63:0] v);
    return {192'b0, v};
  endfunction

  // (index*step - 1)^2 in Q.60
  function automatic wide_t coord_sq(logic [INDEX_W-1:0] idx_in, logic [CFG_W-1:0] step);
    logic [63:0] idx, prod, one, mag;
    idx = idx_in;
    one = 64'd1 << FRAC_STEP;
    if (idx > MAX_POINTS - 1) idx = MAX_POINTS - 1;
    prod = idx * step;
    mag = (prod >= one) ? prod - one : one - prod;
    return unsigned_wide(mag) * unsigned_wide(mag);
  endfunction

  function automatic jsp_out_t predict_point_update(jsp_in_t it);
    wide_t    num, p, mag, q, val, diff, dd, lim;
    logic [63:0] den;
    logic     neg, ovf;
    jsp_out_t r;
    num = (widen(it.below) + widen(it.above)) * unsigned_wide(inv_x)
        + (widen(it.south) + widen(it.north)) * unsigned_wide(inv_y)
        + (widen(it.west) + widen(it.east)) * unsigned_wide(inv_z);
    num = num <<< 20;
    p = coord_sq(it.index_x, stp_x) + coord_sq(it.index_y, stp_y)
      + coord_sq(it.index_z, stp_z);
    num = num + p * unsigned_wide(coef) - (wide_t'(6) <<< 68);
    den = 2 * (64'(inv_x) + 64'(inv_y) + 64'(inv_z)) + 64'(coef);
    neg = num < 0;
    mag = neg ? -num : num;
    lim = (wide_t'(1) <<< (VALUE_W - 1)) - (neg ? 0 : 1);
    ovf = 1'b0;
    if (den == 0) begin
      if (mag == 0) q = 0;
      else begin
        q = lim;
        ovf = 1'b1;
      end
    end else begin
      dd = unsigned_wide(den) <<< 20;
      q = (mag + (dd >>> 1)) / dd;
      if (q > lim) begin
        q = lim;
        ovf = 1'b1;
      end
    end
    val = neg ? -q : q;
    diff = val - widen(it.center_old);
    if (diff < 0) diff = -diff;
    r.new_value = val[VALUE_W-1:0];
    r.exceeded  = diff > unsigned_wide(eps);
    r.overflow  = ovf;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (errors < 30)
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    jsp_out_t want;
    if (!rst_ni) begin
      inv_x <= INV_SQ_RST;
      inv_y <= INV_SQ_RST;
      inv_z <= INV_SQ_RST;
      stp_x <= STEP_RST;
      stp_y <= STEP_RST;
      stp_z <= STEP_RST;
      coef  <= COEF_RST;
      eps   <= EPS_RST;
      expected_points.delete();
      errors  = 0;
      checked = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_points.size() == 0) begin
          report_mismatch("unexpected result", out_data_i, 0);
        end else begin
          want = expected_points.pop_front();
          checked++;
          if (out_data_i.new_value !== want.new_value)
            report_mismatch("new_value", out_data_i.new_value, want.new_value);
          if (out_data_i.exceeded !== want.exceeded)
            report_mismatch("exceeded", out_data_i.exceeded, want.exceeded);
          if (out_data_i.overflow !== want.overflow)
            report_mismatch("overflow", out_data_i.overflow, want.overflow);
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_points.push_back(predict_point_update(in_data_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_INV_SQ_X: inv_x <= cfg_data_i[CFG_W-1:0];
          REG_INV_SQ_Y: inv_y <= cfg_data_i[CFG_W-1:0];
          REG_INV_SQ_Z: inv_z <= cfg_data_i[CFG_W-1:0];
          REG_STEP_X:   stp_x <= cfg_data_i[CFG_W-1:0];
          REG_STEP_Y:   stp_y <= cfg_data_i[CFG_W-1:0];
          REG_STEP_Z:   stp_z <= cfg_data_i[CFG_W-1:0];
          REG_COEF_A:   coef  <= cfg_data_i[CFG_W-1:0];
          REG_EPSILON:  eps   <= cfg_data_i[EPS_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

@@ bench/tb.sv @@
// Testbench top: drives points and register settings into the stencil update and gives the verdict.
`timescale 1ns / 1ps
module tb import jsp_pkg::*; ();

  localparam int LATENCY     = QW + 11;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 168;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  jsp_in_t               in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  jsp_out_t              out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int errors, pending, checked;
  int points_sent, settings_run, idle_cycles, stall_left;
  logic in_gaps, out_gaps;

  always #1 clk_i = ~clk_i;

  jacobi_stencil_point_update DUT (.*);

  jsp_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending), .checked_o(checked)
  );

  // When out_gaps is set, randomly stall the result side while a result is valid.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (out_stall_i) begin
      if (stall_left <= 1) out_stall_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (out_valid_o && out_gaps) begin
      stall_left  <= $urandom_range(0, 6);
      out_stall_i <= ($urandom_range(0, 1) == 1);
    end
  end

  // End the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] ix, logic [31:0] iy, logic [31:0] iz,
                           logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                           logic [31:0] a, logic [EPS_W-1:0] e);
    write_reg(REG_INV_SQ_X, CFG_DATA_W'(ix));
    write_reg(REG_INV_SQ_Y, CFG_DATA_W'(iy));
    write_reg(REG_INV_SQ_Z, CFG_DATA_W'(iz));
    write_reg(REG_STEP_X, CFG_DATA_W'(sx));
    write_reg(REG_STEP_Y, CFG_DATA_W'(sy));
    write_reg(REG_STEP_Z, CFG_DATA_W'(sz));
    write_reg(REG_COEF_A, CFG_DATA_W'(a));
    write_reg(REG_EPSILON, CFG_DATA_W'(e));
    settings_run++;
  endtask

  task automatic send_point(jsp_in_t pt);
    int gap;
    in_data_i  <= pt;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    points_sent++;
    gap = in_gaps ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  function automatic logic [VALUE_W-1:0] rand_value(int kind, logic [VALUE_W-1:0] near);
    logic [63:0] r;
    r = {$urandom, $urandom};
    case (kind)
      0: return r[VALUE_W-1:0];
      1: return near + {{(VALUE_W-12){r[11]}}, r[11:0]};
      default: case ($urandom_range(0, 3))
        0: return {1'b0, {(VALUE_W-1){1'b1}}};
        1: return {1'b1, {(VALUE_W-1){1'b0}}};
        2: return '0;
        default: return '1;
      endcase
    endcase
  endfunction

  function automatic jsp_in_t rand_point();
    jsp_in_t pt;
    int kind;
    logic [63:0] base;
    kind = $urandom_range(0, 9) < 5 ? 1 : ($urandom_range(0, 1) ? 0 : 2);
    base = {$urandom, $urandom};
    // smooth fields sit near a modest value, as in a converging sweep
    if (kind == 1) base = {{(64-44){base[43]}}, base[43:0]};
    pt.center_old = rand_value(kind, base[VALUE_W-1:0]);
    pt.west       = rand_value(kind, base[VALUE_W-1:0]);
    pt.east       = rand_value(kind, base[VALUE_W-1:0]);
    pt.south      = rand_value(kind, base[VALUE_W-1:0]);
    pt.north      = rand_value(kind, base[VALUE_W-1:0]);
    pt.below      = rand_value(kind, base[VALUE_W-1:0]);
    pt.above      = rand_value(kind, base[VALUE_W-1:0]);
    pt.index_x    = INDEX_W'($urandom);
    pt.index_y    = INDEX_W'($urandom);
    pt.index_z    = INDEX_W'($urandom);
    return pt;
  endfunction

  task automatic run_random(int n);
    repeat (n) send_point(rand_point());
  endtask

  task automatic run_directed;
    jsp_in_t pt;
    logic [VALUE_W-1:0] vmax, vmin;
    vmax = {1'b0, {(VALUE_W-1){1'b1}}};
    vmin = {1'b1, {(VALUE_W-1){1'b0}}};
    pt = '0;
    send_point(pt);
    pt = {vmax, vmax, vmax, vmax, vmax, vmax, vmax, 10'h3FF, 10'h3FF, 10'h3FF};
    send_point(pt);
    pt = {vmin, vmin, vmin, vmin, vmin, vmin, vmin, 10'h000, 10'h000, 10'h000};
    send_point(pt);
    pt = {vmin, vmax, vmax, vmax, vmax, vmax, vmax, 10'h3FF, 10'h000, 10'h200};
    send_point(pt);
    pt = {vmax, vmin, vmin, vmin, vmin, vmin, vmin, 10'h000, 10'h3FF, 10'h1FF};
    send_point(pt);
    pt = {{VALUE_W{1'b1}}, {6{{VALUE_W{1'b1}}}}, 10'd1, 10'd2, 10'd511};
    send_point(pt);
    // grid point next to the center: coordinate close to zero at the default spacing
    pt = '0;
    pt.index_x = 10'd239;
    pt.index_y = 10'd239;
    pt.index_z = 10'd239;
    send_point(pt);
    repeat (10) send_point(rand_point());
  endtask

  initial begin
    points_sent  = 0;
    settings_run = 1;
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    in_gaps  = 1'b1;
    out_gaps = 1'b1;
    run_random(PHASE_ITEMS);
    drain();

    write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, EPS_W'({$urandom, $urandom}));
    in_gaps = 1'b0;
    run_directed();
    run_random(PHASE_ITEMS);
    drain();

    write_all('1, '1, '1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1, '1);
    in_gaps  = 1'b1;
    out_gaps = 1'b0;
    run_directed();
    run_random(PHASE_ITEMS);
    drain();

    // zero denominator
    write_all('0, '0, '0, '0, '0, '0, '0, '0);
    out_gaps = 1'b1;
    run_directed();
    run_random(PHASE_ITEMS / 2);
    drain();

    // tiny denominator drives the quotient into saturation
    write_all(32'd1, 32'd0, 32'd1, $urandom, $urandom, $urandom, 32'd0, '0);
    run_directed();
    run_random(PHASE_ITEMS);
    drain();

    write_all($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
              '1, '1, '1, $urandom_range(0, 1023), EPS_W'({$urandom, $urandom}));
    in_gaps = 1'b0;
    run_random(PHASE_ITEMS);
    drain();

    write_all($urandom, $urandom, $urandom, $urandom_range(0, 32'h8000_0000),
              $urandom_range(0, 32'h8000_0000), $urandom_range(0, 32'h8000_0000),
              $urandom, EPS_W'($urandom_range(0, 1 << 20)));
    in_gaps = 1'b1;
    run_random(PHASE_ITEMS);
    drain();

    write_all(INV_SQ_RST, INV_SQ_RST, INV_SQ_RST, STEP_RST, STEP_RST, STEP_RST,
              COEF_RST, EPS_RST);
    run_random(PHASE_ITEMS);
    drain();

    $display("Sent %0d grid points over %0d register settings; %0d results checked.",
             points_sent, settings_run, checked);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
